// ----- rtl/b64lw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package b64lw_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [5:0] LINE_GROUPS_RESET = 6'd19;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] PAD_CHAR     = 8'h3D;

    // One finished group handed from the front to the back
    typedef struct packed {
        logic [23:0] word;     // three bytes, zero-padded on the right
        logic [1:0]  fill;     // bytes present, 1..3
        logic        last;     // group ends the stream
        logic        newline;  // a newline goes out before the group
    } group_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Standard base64 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26)
            c = 8'd65 + {2'b00, idx};
        else if (idx < 6'd52)
            c = 8'd71 + {2'b00, idx};          // 'a' - 26
        else if (idx < 6'd62)
            c = {2'b00, idx} - 8'd4;           // '0' - 52
        else if (idx == 6'd62)
            c = 8'h2B;                         // '+'
        else
            c = 8'h2F;                         // '/'
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/b64lw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64lw_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               is_last,
    input  wire logic [5:0]         line_groups,
    input  wire b64lw_pkg::queue_status_t q_status,
    output logic                    q_push,
    output b64lw_pkg::group_t       q_data
);

    logic [15:0] held_reg, held_next;
    logic [1:0]  fill_reg, fill_next;
    logic [5:0]  gol_reg, gol_next;

    logic       in_fire;
    logic [1:0] fill;
    logic       emit;
    logic       newline;

    // Hold off only while the queue has no room
    assign in_stall = q_status.full;
    assign in_fire  = in_valid && !in_stall;

    assign fill    = fill_reg + 2'd1;
    assign emit    = (fill == 2'd3) || is_last;
    assign newline = (line_groups != 6'd0) && (gol_reg >= line_groups);

    // Group descriptor, left aligned
    always_comb
    begin
        q_data.fill    = fill;
        q_data.last    = is_last;
        q_data.newline = newline;
        unique case (fill)
            2'd1:    q_data.word = {data_byte, 16'h0000};
            2'd2:    q_data.word = {held_reg[7:0], data_byte, 8'h00};
            default: q_data.word = {held_reg, data_byte};
        endcase
    end

    assign q_push = in_fire && emit;

    // Group and line bookkeeping
    always_comb
    begin
        held_next = held_reg;
        fill_next = fill_reg;
        gol_next  = gol_reg;
        if (in_fire)
        begin
            if (!emit)
            begin
                held_next = {held_reg[7:0], data_byte};
                fill_next = fill;
            end
            else
            begin
                held_next = 16'h0000;
                fill_next = 2'd0;
                if (is_last || line_groups == 6'd0)
                    gol_next = 6'd0;
                else
                    gol_next = (newline ? 6'd0 : gol_reg) + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 16'h0000;
            fill_reg <= 2'd0;
            gol_reg  <= 6'd0;
        end
        else
        begin
            held_reg <= held_next;
            fill_reg <= fill_next;
            gol_reg  <= gol_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/b64lw_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64lw_queue #(
    parameter int DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire b64lw_pkg::group_t   push_data,
    input  wire logic                pop,
    output b64lw_pkg::group_t        pop_data,
    output b64lw_pkg::queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64lw_pkg::group_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    // Storage write
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/b64lw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64lw_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire b64lw_pkg::queue_status_t q_status,
    input  wire b64lw_pkg::group_t   q_data,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [7:0]               out_char,
    output logic                     out_last
);

    // step 0 is the newline, steps 1..4 the group characters
    localparam logic [2:0] STEP_NL   = 3'd0;
    localparam logic [2:0] STEP_C0   = 3'd1;
    localparam logic [2:0] STEP_DONE = 3'd4;

    b64lw_pkg::group_t desc_reg, desc_next;
    logic       busy_reg, busy_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_last_reg, out_last_next;

    logic       advance;
    logic       emitting;
    logic       finishing;
    logic [1:0] pos;
    logic [5:0] sextet;
    logic [7:0] chr;

    assign advance   = !out_valid_reg || !out_stall;
    assign emitting  = advance && busy_reg;
    assign finishing = emitting && (step_reg == STEP_DONE);
    assign q_pop     = !q_status.empty && (!busy_reg || finishing);

    // Character for the current step
    assign pos = 2'(step_reg - STEP_C0);
    always_comb
    begin
        unique case (pos)
            2'd0:    sextet = desc_reg.word[23:18];
            2'd1:    sextet = desc_reg.word[17:12];
            2'd2:    sextet = desc_reg.word[11:6];
            default: sextet = desc_reg.word[5:0];
        endcase
        if (step_reg == STEP_NL)
            chr = b64lw_pkg::NEWLINE_CHAR;
        else if (pos > desc_reg.fill)
            chr = b64lw_pkg::PAD_CHAR;
        else
            chr = b64lw_pkg::b64_char(sextet);
    end

    // Sequencer and output register
    always_comb
    begin
        desc_next      = desc_reg;
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (advance)
            out_valid_next = busy_reg;
        if (emitting)
        begin
            out_char_next = chr;
            out_last_next = desc_reg.last && (step_reg == STEP_DONE);
            step_next     = step_reg + 3'd1;
        end
        if (finishing)
            busy_next = 1'b0;
        if (q_pop)
        begin
            desc_next = q_data;
            busy_next = 1'b1;
            step_next = q_data.newline ? STEP_NL : STEP_C0;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg     <= desc_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_NL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/base64_encoder_line_wrap_core.sv -----
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  data_byte[7:0], is_last
// out       output     out_valid/out_stall out_char[7:0], out_last
// cfg       input      cfg_we             cfg_wdata[5:0] (line_groups)
//
// One byte is taken per cycle while the group queue has room; the back end
// sends one character per cycle while out_stall is low and loads the next group
// as the current one finishes; the character sequencer in the back end paces
// the output. Reset clears the group and line state and the queue;
// line_groups goes to 19. Output stalls back up into the queue and then into
// in_stall.
`timescale 1ns / 1ps
`default_nettype none

module base64_encoder_line_wrap_core #(
    parameter int QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       is_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_char,
    output logic            out_last,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata
);

    logic [5:0] line_groups_reg;

    b64lw_pkg::queue_status_t q_status;
    b64lw_pkg::group_t        push_data;
    b64lw_pkg::group_t        pop_data;
    logic                     q_push;
    logic                     q_pop;

    // Line length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_groups_reg <= b64lw_pkg::LINE_GROUPS_RESET;
        else if (cfg_we)
            line_groups_reg <= cfg_wdata;
    end

    b64lw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .is_last     (is_last),
        .line_groups (line_groups_reg),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    b64lw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .out_last  (out_last)
    );

`ifndef ASSERT_OFF
    // No group is pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full))
        else $error("group pushed into full queue");

    // The back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_status.empty))
        else $error("pop from empty queue");

    // A last byte always closes a group
    a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && is_last) |-> q_push)
        else $error("last byte did not flush a group");

    // A newline never ends the stream
    a_newline_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_char == b64lw_pkg::NEWLINE_CHAR) |-> !out_last)
        else $error("newline marked as last");
`endif

endmodule

`default_nettype wire
